// ===== rtl/core/sparse_transpose_hadamard_macros.svh =====
// assertion helpers for the sparse hadamard block
`ifndef SPARSE_TRANSPOSE_HADAMARD_MACROS_SVH
`define SPARSE_TRANSPOSE_HADAMARD_MACROS_SVH
// implication checked at every edge outside reset
`define STH_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define STH_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/sth_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sth_pkg
// types and codes shared by the sparse transpose hadamard block
// ----------------------------------------------------------------------------
package sth_pkg;
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_LOAD_RP = 3'd1;
  localparam logic [2:0] CMD_LOAD_EN = 3'd2;
  localparam logic [2:0] CMD_NZ      = 3'd3;
  localparam logic [2:0] CMD_ROW_END = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [12:0] address;
    logic [12:0] pointer;
    logic [9:0]  row;
    logic [9:0]  column;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [19:0] out_index;
    logic [9:0]  out_column;
    logic signed [31:0] product;
    logic [9:0]  finished_row;
    logic [19:0] row_end_total;
  } out_t;
endpackage
`default_nettype wire

// ===== rtl/core/sth_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sth_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module sth_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  sth_pkg::in_t      push_data,
  output logic              full,
  output logic              empty,
  input  wire logic         pop,
  output sth_pkg::in_t      pop_data
);
  sth_pkg::in_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push && !full) - 2'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sth_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sth_front
// takes requests, drops unused commands, forwards the rest to the queue
// ----------------------------------------------------------------------------
module sth_front (
  input  sth_pkg::in_t in_data,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         push,
  output sth_pkg::in_t push_data,
  input  wire logic    full
);
  logic useful;

  always_comb begin
    unique case (in_data.command)
      sth_pkg::CMD_START, sth_pkg::CMD_LOAD_RP, sth_pkg::CMD_LOAD_EN,
      sth_pkg::CMD_NZ, sth_pkg::CMD_ROW_END: useful = 1'b1;
      default: useful = 1'b0;
    endcase
  end

  assign in_ready  = !full;
  assign push      = in_valid && useful;
  assign push_data = in_data;
endmodule
`default_nettype wire

// ===== rtl/core/sth_back.sv =====
`default_nettype none
`include "sparse_transpose_hadamard_macros.svh"
// ----------------------------------------------------------------------------
// sth_back
// memories, binary search, product and output register
// ----------------------------------------------------------------------------
module sth_back #(
  parameter int ROWS         = 1024,
  parameter int ENTRIES      = 4096,
  parameter int OUT_CAPACITY = 1048576
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    empty,
  output logic         pop,
  input  sth_pkg::in_t req,
  output logic         out_valid,
  input  wire logic    out_ready,
  output sth_pkg::out_t out_data
);
  localparam int RW = $clog2(ROWS + 1);
  localparam int EW = $clog2(ENTRIES);
  localparam int PW = $clog2(ENTRIES + 1);
  localparam int LIM_I = (OUT_CAPACITY - 1 < 1048575) ? OUT_CAPACITY - 1 : 1048575;
  localparam logic [19:0] LIMIT = 20'(LIM_I);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PTR0 = 3'd1;
  localparam logic [2:0] S_PTR1 = 3'd2;
  localparam logic [2:0] S_LOOP = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_MUL  = 3'd6;
  localparam logic [2:0] S_RND  = 3'd7;

  logic [12:0] rp_mem [ROWS + 1];
  logic [9:0]  col_mem [ENTRIES];
  logic [31:0] val_mem [ENTRIES];

  logic [2:0]  state;
  logic [RW-1:0] rp_addr;
  logic [12:0] rp_q;
  logic [EW-1:0] en_addr;
  logic [9:0]  col_q;
  logic [31:0] val_q;
  logic [PW-1:0] lo, hi, fin;
  logic [19:0] out_count;
  logic signed [63:0] prod;
  sth_pkg::in_t cur;

  logic [PW-1:0] rp_clamp;
  logic [PW-1:0] mid;
  logic signed [64:0] rnd;
  logic signed [48:0] q;
  logic signed [31:0] sat;
  logic take;
  logic emit_end;
  logic emit_prod;

  assign take = !out_valid || out_ready;
  assign rp_clamp = ({19'd0, rp_q} > 32'(ENTRIES)) ? PW'(ENTRIES) : PW'(rp_q);
  assign mid = lo + ((hi - lo) >> 1);
  assign rnd = 65'(prod) + 65'sd32768;
  assign q = rnd[64:16];
  assign sat = (q > 49'sd2147483647) ? 32'sh7fffffff :
               (q < -49'sd2147483648) ? 32'sh80000000 : q[31:0];

  // result register loads: a row end from idle, or a rounded product
  assign emit_end  = (state == S_IDLE) && !empty &&
                     (req.command == sth_pkg::CMD_ROW_END) && take;
  assign emit_prod = (state == S_RND) && take;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && !empty && req.command == sth_pkg::CMD_LOAD_RP &&
        {19'd0, req.address} <= 32'(ROWS)) rp_mem[RW'(req.address)] <= req.pointer;
    if (state == S_IDLE && !empty && req.command == sth_pkg::CMD_LOAD_EN &&
        {19'd0, req.address} < 32'(ENTRIES)) begin
      col_mem[EW'(req.address)] <= req.column;
      val_mem[EW'(req.address)] <= req.value;
    end
    rp_q  <= rp_mem[rp_addr];
    col_q <= col_mem[en_addr];
    val_q <= val_mem[en_addr];
  end

  always_comb begin
    pop = 1'b0;
    if (state == S_IDLE && !empty) begin
      unique case (req.command)
        sth_pkg::CMD_ROW_END: pop = take;
        default: pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      out_count <= '0;
    end else begin
      out_valid <= emit_end || emit_prod || (out_valid && !out_ready);
      if (emit_end) begin
        out_data <= '{kind: 1'b1, out_index: '0, out_column: '0,
                      product: '0, finished_row: req.row,
                      row_end_total: out_count};
      end else if (emit_prod) begin
        out_data <= '{kind: 1'b0, out_index: out_count, out_column: cur.column,
                      product: sat, finished_row: '0, row_end_total: '0};
      end
      unique case (state)
        S_IDLE: if (!empty) begin
          cur <= req;
          unique case (req.command)
            sth_pkg::CMD_START: out_count <= '0;
            sth_pkg::CMD_NZ: if ({22'd0, req.column} < 32'(ROWS)) begin
              rp_addr <= RW'(req.column);
              state   <= S_PTR0;
            end
            default: ;
          endcase
        end
        S_PTR0: begin
          rp_addr <= rp_addr + 1'b1;
          state   <= S_PTR1;
        end
        S_PTR1: begin
          lo    <= rp_clamp;
          state <= S_LOOP;
        end
        S_LOOP: begin
          hi      <= rp_clamp;
          fin     <= rp_clamp;
          state   <= (lo >= rp_clamp) ? S_IDLE : S_RD;
          en_addr <= EW'(lo + ((rp_clamp - lo) >> 1));
        end
        S_RD: begin
          state <= S_CHK;
          if (lo < hi) begin
            en_addr <= EW'(mid);
          end else begin
            // search done: read the landing slot, hi cleared marks the check
            en_addr <= EW'(lo);
            hi      <= '0;
          end
        end
        S_CHK: state <= S_MUL;
        // address set in S_RD, read data registered during S_CHK and used in S_MUL
        S_MUL: begin
          if (lo < hi) begin
            if (col_q < cur.row) lo <= PW'(en_addr) + 1'b1;
            else hi <= PW'(en_addr);
            state <= S_RD;
          end else if (lo < fin && col_q == cur.row) begin
            prod  <= $signed(cur.value) * $signed(val_q);
            state <= S_RND;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RND: if (take) begin
          if (out_count < LIMIT) out_count <= out_count + 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `STH_ASSERT_IMP(a_lim, clk, rst, 1'b1, out_count <= LIMIT)
  `STH_ASSERT_IMP(a_pop, clk, rst, pop, !empty)
  `STH_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

// ===== rtl/core/sparse_transpose_hadamard.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_transpose_hadamard
// csr hadamard product of a with the transpose of c
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready, in_data) carries requests: start pass,
//   load c row pointer, load c entry, a nonzero, end of a row;
//   unused commands are taken and dropped
//   out channel (out_valid/out_ready, out_data) carries product entries
//   and end-of-row pointers
//   front takes requests into a two-entry queue; back runs them in order,
//   starting the cycle after acceptance when it is idle and the queue was empty
//   loads, start and row ends are handled in idle; a row end waits for take
//   an a nonzero passes through S_PTR0, S_PTR1 and S_LOOP and stops there on an
//   empty c row; else S_RD, S_CHK and S_MUL repeat for each of s search steps
//   plus a final check, s at most floor(log2(n)) + 1 for a row of n entries;
//   a hit adds S_RND, which waits for the output register; one request at a time
//   at reset the output count clears; c memories hold garbage until loaded
//   a stalled receiver holds the output register; the back then waits and
//   the queue fills, dropping in_ready
// ----------------------------------------------------------------------------
module sparse_transpose_hadamard #(
  parameter int ROWS         = 1024,
  parameter int ENTRIES      = 4096,
  parameter int OUT_CAPACITY = 1048576
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  sth_pkg::in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sth_pkg::out_t out_data
);
  logic         push, full, empty, pop;
  sth_pkg::in_t push_data, pop_data;

  // request classification
  sth_front u_front (
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .push(push), .push_data(push_data), .full(full)
  );

  // decoupling queue
  sth_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .full(full), .empty(empty), .pop(pop), .pop_data(pop_data)
  );

  // search and multiply engine
  sth_back #(.ROWS(ROWS), .ENTRIES(ENTRIES), .OUT_CAPACITY(OUT_CAPACITY)) u_back (
    .clk(clk), .rst(rst), .empty(empty), .pop(pop), .req(pop_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

// ===== test/sparse_transpose_hadamard_tb.sv =====
// ----------------------------------------------------------------------------
// sparse_transpose_hadamard_tb
// self-checking bench for the csr hadamard product with transpose
// ----------------------------------------------------------------------------
// loads small c matrices, streams a nonzeros and row ends, and checks every
// result against an in-bench predictor of the search, the rounded saturated
// product and the output count, under several idle and stall patterns
// ----------------------------------------------------------------------------
module sparse_transpose_hadamard_tb;
  localparam int NROWS     = 1024;
  localparam int NENTRIES  = 4096;
  localparam int COUNT_MAX = 1048575;
  localparam int WATCHDOG  = 20000;
  localparam logic [2:0] CMD_SPARE     = 3'd5;
  localparam logic [2:0] CMD_SPARE_TOP = 3'd7;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  sth_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  sth_pkg::out_t out_data;

  sparse_transpose_hadamard DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor copy of the c matrix and the running count
  logic [12:0] c_row_start [0:NROWS];
  logic [9:0]  c_col [0:NENTRIES-1];
  logic [31:0] c_val [0:NENTRIES-1];
  logic [19:0] pred_count;

  sth_pkg::out_t expected_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_request;
  int hold_left;
  int mismatches;
  int idle_cycles;
  bit timed_out;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rounded q16.16 multiply with saturation
  function automatic logic [31:0] q16_mul(logic signed [31:0] a, logic signed [31:0] c);
    logic signed [63:0] p;
    logic signed [63:0] q;
    p = 64'(a) * 64'(c) + 64'sd32768;
    q = p >>> 16;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // update the predictor with one request; queue any result it causes
  task automatic predict_request(input sth_pkg::in_t req);
    int lo, hi, last, mid;
    sth_pkg::out_t res;
    res = '0;
    case (req.command)
      sth_pkg::CMD_START: pred_count = '0;
      sth_pkg::CMD_LOAD_RP: if (req.address <= NROWS) c_row_start[req.address] = req.pointer;
      sth_pkg::CMD_LOAD_EN: if (req.address < NENTRIES) begin
        c_col[req.address] = req.column;
        c_val[req.address] = req.value;
      end
      sth_pkg::CMD_NZ: begin
        lo = c_row_start[req.column];
        hi = c_row_start[req.column + 1];
        if (lo > NENTRIES) lo = NENTRIES;
        if (hi > NENTRIES) hi = NENTRIES;
        last = hi;
        if (lo < hi) begin
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (c_col[mid] < req.row) lo = mid + 1;
            else hi = mid;
          end
          if (lo < last && c_col[lo] == req.row) begin
            res.out_index = pred_count;
            res.out_column = req.column;
            res.product = q16_mul(req.value, c_val[lo]);
            expected_results = {expected_results, res};
            if (pred_count < COUNT_MAX) pred_count++;
          end
        end
      end
      sth_pkg::CMD_ROW_END: begin
        res.kind = 1'b1;
        res.finished_row = req.row;
        res.row_end_total = pred_count;
        expected_results = {expected_results, res};
      end
      default: ;
    endcase
  endtask

  // drive one request, honoring the current idle percentage
  task automatic send_request(input sth_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(req);
    @(negedge clk);
  endtask

  // receiver side: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off_request > 0) begin
      hold_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    sth_pkg::out_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.kind !== exp_res.kind || out_data.out_index !== exp_res.out_index ||
            out_data.out_column !== exp_res.out_column ||
            out_data.product !== exp_res.product ||
            out_data.finished_row !== exp_res.finished_row ||
            out_data.row_end_total !== exp_res.row_end_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_res, out_data);
        end
      end
    end
  end

  // watchdog: cycles with no accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic sth_pkg::in_t make_request(logic [2:0] cmd, int addr, int ptr, int r,
                                                int col, logic [31:0] val);
    sth_pkg::in_t req;
    req.command = cmd;
    req.address = 13'(addr);
    req.pointer = 13'(ptr);
    req.row     = 10'(r);
    req.column  = 10'(col);
    req.value   = val;
    return req;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // c matrix: a few rows of sorted random columns at the bottom and top of
  // the row range; only the row pointers around them are written
  task automatic load_c_matrix(input int max_len);
    int slot, len, r, k, col;
    slot = 0;
    for (r = 0; r < NROWS; r++) begin
      if (r < 25 || r >= 1020)
        send_request(make_request(sth_pkg::CMD_LOAD_RP, r, slot, $urandom, $urandom,
                                  $urandom));
      len = (r < 24 || r >= 1020) ? $urandom_range(max_len) : 0;
      col = $urandom_range(3);
      for (k = 0; k < len; k++) begin
        if (col > 1023) col = 1023;
        send_request(make_request(sth_pkg::CMD_LOAD_EN, slot, $urandom, $urandom, col,
                                  $urandom));
        slot++;
        col += $urandom_range(1, 60);
      end
    end
    send_request(make_request(sth_pkg::CMD_LOAD_RP, NROWS, slot, $urandom, $urandom,
                              $urandom));
  endtask

  // a row item that mostly hits a stored column of c
  task automatic send_nonzero(input int i);
    int j, lo, hi;
    j = $urandom_range(1) ? $urandom_range(23) : $urandom_range(1020, 1023);
    lo = c_row_start[j];
    hi = c_row_start[j + 1];
    if (hi > lo && $urandom_range(3) != 0) i = c_col[$urandom_range(lo, hi - 1)];
    send_request(make_request(sth_pkg::CMD_NZ, $urandom, $urandom, i, j, $urandom));
  endtask

  task automatic test_directed();
    // special cases: out-of-range loads, spare commands, extreme products
    send_request(make_request(sth_pkg::CMD_LOAD_RP, 13'h1fff, 13'h1fff, 0, 0, 0));
    send_request(make_request(sth_pkg::CMD_LOAD_EN, 13'h1fff, 0, 0, 10'h3ff, 32'hffffffff));
    send_request(make_request(CMD_SPARE, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_SPARE_TOP, 13'h1fff, 13'h1fff, 10'h3ff, 10'h3ff,
                              32'hffffffff));
    send_request(make_request(sth_pkg::CMD_START, 0, 0, 0, 0, 0));
    // row 0 holds cols 0,5,5,1023; row 1 empty; row 3 starts past memory;
    // row 4 ends past memory and holds the last slot
    send_request(make_request(sth_pkg::CMD_LOAD_RP, 0, 0, 0, 0, 0));
    send_request(make_request(sth_pkg::CMD_LOAD_RP, 1, 4, 0, 0, 0));
    send_request(make_request(sth_pkg::CMD_LOAD_RP, 2, 4, 0, 0, 0));
    send_request(make_request(sth_pkg::CMD_LOAD_RP, 3, 13'h1fff, 0, 0, 0));
    send_request(make_request(sth_pkg::CMD_LOAD_RP, 4, NENTRIES - 1, 0, 0, 0));
    send_request(make_request(sth_pkg::CMD_LOAD_RP, 5, 13'h1fff, 0, 0, 0));
    send_request(make_request(sth_pkg::CMD_LOAD_EN, 0, 0, 0, 0, 32'h7fffffff));
    send_request(make_request(sth_pkg::CMD_LOAD_EN, 1, 0, 0, 5, 32'h80000000));
    send_request(make_request(sth_pkg::CMD_LOAD_EN, 2, 0, 0, 5, 32'h00010000));
    send_request(make_request(sth_pkg::CMD_LOAD_EN, 3, 0, 0, 1023, 32'hffff8000));
    send_request(make_request(sth_pkg::CMD_LOAD_EN, NENTRIES - 1, 0, 0, 7, 32'h00018000));
    send_request(make_request(sth_pkg::CMD_NZ, 0, 0, 0, 0, 32'h7fffffff));
    send_request(make_request(sth_pkg::CMD_NZ, 0, 0, 5, 0, 32'h7fffffff));
    send_request(make_request(sth_pkg::CMD_NZ, 0, 0, 1023, 0, 32'h00008000));
    send_request(make_request(sth_pkg::CMD_NZ, 0, 0, 6, 0, 32'h00010000));
    send_request(make_request(sth_pkg::CMD_NZ, 0, 0, 0, 1, 32'h00010000));
    send_request(make_request(sth_pkg::CMD_NZ, 0, 0, 0, 3, 32'h00010000));
    send_request(make_request(sth_pkg::CMD_NZ, 0, 0, 7, 4, 32'h00010000));
    send_request(make_request(sth_pkg::CMD_ROW_END, 0, 0, 10'h3ff, 0, 0));
    send_request(make_request(sth_pkg::CMD_START, 0, 0, 0, 0, 0));
    send_request(make_request(sth_pkg::CMD_ROW_END, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  // rows of a in order with random nonzeros, some noise mixed in
  task automatic test_random_pass(input int n_items);
    int sent, i;
    send_request(make_request(sth_pkg::CMD_START, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
    sent = 0;
    i = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: send_request(make_request(sth_pkg::CMD_ROW_END, $urandom, $urandom, i, $urandom,
                                     $urandom));
        1: send_request(make_request(3'($urandom_range(CMD_SPARE, CMD_SPARE_TOP)), $urandom,
                                     $urandom, $urandom, $urandom, $urandom));
        2: send_request(make_request(sth_pkg::CMD_START, $urandom, $urandom, $urandom,
                                     $urandom, $urandom));
        default: send_nonzero(i);
      endcase
      if ($urandom_range(7) == 0) begin
        send_request(make_request(sth_pkg::CMD_ROW_END, $urandom, $urandom, i, $urandom,
                                  $urandom));
        i = (i + 1) % NROWS;
      end
      sent++;
    end
  endtask

  // receiver holds off long so the queue fills and in_ready drops
  task automatic test_backpressure();
    hold_off_request = 400;
    test_random_pass(40);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_request = 0;
    hold_left = 0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    load_c_matrix(40);
    test_random_pass(150);
    send_idle_pct = 52;
    test_random_pass(120);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    test_random_pass(120);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    test_random_pass(120);
    // sender pauses until everything has come out
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    load_c_matrix(6);
    test_random_pass(60);

    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sth_pkg.sv
rtl/core/sth_queue.sv
rtl/core/sth_front.sv
rtl/core/sth_back.sv
rtl/core/sparse_transpose_hadamard.sv
test/sparse_transpose_hadamard_tb.sv
